@@ design/c8alu_pkg.sv @@
package c8alu_pkg;

    localparam int FUNC_W     = 5;
    localparam int WORD16_W   = 16;
    localparam int BIT_IDX_W  = 3;
    localparam int IN_TDATA_W = 48;   // 44 bits of fields, padded to 6 bytes
    localparam int OUT_TDATA_W = 24;  // 20 bits of fields, padded to 3 bytes

    // Operation codes; code 31 is unused and passes operand_a through
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 5'd0,
        FN_ADC   = 5'd1,
        FN_SUB   = 5'd2,
        FN_SBC   = 5'd3,
        FN_AND   = 5'd4,
        FN_XOR   = 5'd5,
        FN_OR    = 5'd6,
        FN_CP    = 5'd7,
        FN_INC   = 5'd8,
        FN_DEC   = 5'd9,
        FN_RLCA  = 5'd10,
        FN_RRCA  = 5'd11,
        FN_RLA   = 5'd12,
        FN_RRA   = 5'd13,
        FN_CPL   = 5'd14,
        FN_SCF   = 5'd15,
        FN_CCF   = 5'd16,
        FN_RLC   = 5'd17,
        FN_RRC   = 5'd18,
        FN_RL    = 5'd19,
        FN_RR    = 5'd20,
        FN_SLA   = 5'd21,
        FN_SRA   = 5'd22,
        FN_SWAP  = 5'd23,
        FN_SRL   = 5'd24,
        FN_BIT   = 5'd25,
        FN_RES   = 5'd26,
        FN_SET   = 5'd27,
        FN_ADD16 = 5'd28,
        FN_INC16 = 5'd29,
        FN_DEC16 = 5'd30
    } func_t;

    typedef struct packed {
        logic zero;
        logic subtract;
        logic half;
        logic carry;
    } flags_t;

    typedef struct packed {
        func_t                 func;
        logic [WORD16_W-1:0]   operand_a;
        logic [WORD16_W-1:0]   operand_b;
        logic [BIT_IDX_W-1:0]  bit_index;
        flags_t                flags;
    } alu_op_t;

    typedef struct packed {
        logic [WORD16_W-1:0]   result;
        flags_t                flags;
    } alu_res_t;

endpackage

@@ design/cpu8_alu_with_flags.sv @@
// Z80-style 8-bit ALU with flags. Each input word carries one operation
// (function code, two operands, a bit index and the incoming Z/N/H/C flags);
// each output word carries the result and the new flags. The block has two
// register stages: an operand register and a result register, with the whole
// operation decoded and computed by one pass of combinational logic between
// them. A word is accepted every clock cycle when the output side keeps up,
// and every result is presented from the result register. When the
// output side stalls, both stages fill and s_axis_tready drops; it returns
// as soon as the result register is taken. No state is kept between
// operations, so results depend only on their own input word. Unused
// function code 31 returns operand_a unchanged with the flags passed through.
// 8-bit operations return their value zero-extended to 16 bits; CP, BIT, SCF
// and CCF return the low byte of operand_a.
module cpu8_alu_with_flags
    import c8alu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_axis_tdata, low bit up: func[4:0], operand_a[20:5], operand_b[36:21],
    // bit_index[39:37], zero_in[40], subtract_in[41], half_in[42],
    // carry_in[43], zero padding[47:44]
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // m_axis_tdata, low bit up: result[15:0], zero_out[16], subtract_out[17],
    // half_out[18], carry_out[19], zero padding[23:20]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // ---------------------------------------------------------------
    // Stage handshakes
    // ---------------------------------------------------------------
    logic     op_valid_reg;
    alu_op_t  op_reg;
    logic     res_valid_reg;
    alu_res_t res_reg;
    alu_res_t res_next;

    logic     res_load;   // result register takes the operand stage
    logic     op_load;    // operand register takes a new input word

    assign res_load      = op_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !op_valid_reg || res_load;
    assign op_load       = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // Operand register: unpack the input word
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            op_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_load)
        begin
            op_reg.func           <= func_t'(s_axis_tdata[4:0]);
            op_reg.operand_a      <= s_axis_tdata[20:5];
            op_reg.operand_b      <= s_axis_tdata[36:21];
            op_reg.bit_index      <= s_axis_tdata[39:37];
            op_reg.flags.zero     <= s_axis_tdata[40];
            op_reg.flags.subtract <= s_axis_tdata[41];
            op_reg.flags.half     <= s_axis_tdata[42];
            op_reg.flags.carry    <= s_axis_tdata[43];
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin;
    logic [8:0]  add9;
    logic [4:0]  add_nib;
    logic [8:0]  sub9;
    logic [4:0]  sub_nib;
    logic [7:0]  bit_mask;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [7:0]  r8;

    always_comb
    begin
        a8       = op_reg.operand_a[7:0];
        b8       = op_reg.operand_b[7:0];
        // carry in counts only for ADC and SBC
        cin      = ((op_reg.func == FN_ADC) || (op_reg.func == FN_SBC))
                   ? op_reg.flags.carry : 1'b0;
        add9     = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
        add_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
        // bit 8 / bit 4 of the wrapped difference is the borrow
        sub9     = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
        sub_nib  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
        bit_mask = 8'd1 << op_reg.bit_index;
        add17    = {1'b0, op_reg.operand_a} + {1'b0, op_reg.operand_b};
        add13    = {1'b0, op_reg.operand_a[11:0]} + {1'b0, op_reg.operand_b[11:0]};
    end

    always_comb
    begin
        r8                = a8;
        res_next.result   = {8'd0, a8};
        res_next.flags    = op_reg.flags;

        case (op_reg.func)
            FN_ADD, FN_ADC:
            begin
                r8                      = add9[7:0];
                res_next.flags.zero     = (add9[7:0] == 8'd0);
                res_next.flags.subtract = 1'b0;
                res_next.flags.half     = add_nib[4];
                res_next.flags.carry    = add9[8];
            end
            FN_SUB, FN_SBC, FN_CP:
            begin
                // compare keeps operand_a as the result
                r8                      = (op_reg.func == FN_CP) ? a8 : sub9[7:0];
                res_next.flags.zero     = (sub9[7:0] == 8'd0);
                res_next.flags.subtract = 1'b1;
                res_next.flags.half     = sub_nib[4];
                res_next.flags.carry    = sub9[8];
            end
            FN_AND:
            begin
                r8             = a8 & b8;
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b1, carry: 1'b0};
            end
            FN_XOR:
            begin
                r8             = a8 ^ b8;
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b0, carry: 1'b0};
            end
            FN_OR:
            begin
                r8             = a8 | b8;
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b0, carry: 1'b0};
            end
            FN_INC:
            begin
                r8                      = a8 + 8'd1;
                res_next.flags.zero     = (r8 == 8'd0);
                res_next.flags.subtract = 1'b0;
                res_next.flags.half     = (a8[3:0] == 4'hF);
            end
            FN_DEC:
            begin
                r8                      = a8 - 8'd1;
                res_next.flags.zero     = (r8 == 8'd0);
                res_next.flags.subtract = 1'b1;
                res_next.flags.half     = (a8[3:0] == 4'h0);
            end
            FN_RLCA, FN_RLC:
            begin
                r8             = {a8[6:0], a8[7]};
                res_next.flags = '{zero: (op_reg.func == FN_RLC) && (r8 == 8'd0),
                                   subtract: 1'b0, half: 1'b0, carry: a8[7]};
            end
            FN_RRCA, FN_RRC:
            begin
                r8             = {a8[0], a8[7:1]};
                res_next.flags = '{zero: (op_reg.func == FN_RRC) && (r8 == 8'd0),
                                   subtract: 1'b0, half: 1'b0, carry: a8[0]};
            end
            FN_RLA, FN_RL:
            begin
                r8             = {a8[6:0], op_reg.flags.carry};
                res_next.flags = '{zero: (op_reg.func == FN_RL) && (r8 == 8'd0),
                                   subtract: 1'b0, half: 1'b0, carry: a8[7]};
            end
            FN_RRA, FN_RR:
            begin
                r8             = {op_reg.flags.carry, a8[7:1]};
                res_next.flags = '{zero: (op_reg.func == FN_RR) && (r8 == 8'd0),
                                   subtract: 1'b0, half: 1'b0, carry: a8[0]};
            end
            FN_CPL:
            begin
                r8                      = ~a8;
                res_next.flags.subtract = 1'b1;
                res_next.flags.half     = 1'b1;
            end
            FN_SCF:
            begin
                res_next.flags.subtract = 1'b0;
                res_next.flags.half     = 1'b0;
                res_next.flags.carry    = 1'b1;
            end
            FN_CCF:
            begin
                res_next.flags.subtract = 1'b0;
                res_next.flags.half     = 1'b0;
                res_next.flags.carry    = ~op_reg.flags.carry;
            end
            FN_SLA:
            begin
                r8             = {a8[6:0], 1'b0};
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b0, carry: a8[7]};
            end
            FN_SRA:
            begin
                r8             = {a8[7], a8[7:1]};
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b0, carry: a8[0]};
            end
            FN_SWAP:
            begin
                r8             = {a8[3:0], a8[7:4]};
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b0, carry: 1'b0};
            end
            FN_SRL:
            begin
                r8             = {1'b0, a8[7:1]};
                res_next.flags = '{zero: (r8 == 8'd0), subtract: 1'b0,
                                   half: 1'b0, carry: a8[0]};
            end
            FN_BIT:
            begin
                res_next.flags.zero     = ((a8 & bit_mask) == 8'd0);
                res_next.flags.subtract = 1'b0;
                res_next.flags.half     = 1'b1;
            end
            FN_RES:
            begin
                r8 = a8 & ~bit_mask;
            end
            FN_SET:
            begin
                r8 = a8 | bit_mask;
            end
            default:
            begin
                r8 = a8;
            end
        endcase

        // 16-bit ops and the unused code take the full width; others zero-extend
        case (op_reg.func)
            FN_ADD16:
            begin
                res_next.result         = add17[15:0];
                res_next.flags.subtract = 1'b0;
                res_next.flags.half     = add13[12];
                res_next.flags.carry    = add17[16];
            end
            FN_INC16: res_next.result = op_reg.operand_a + 16'd1;
            FN_DEC16: res_next.result = op_reg.operand_a - 16'd1;
            FN_ADD, FN_ADC, FN_SUB, FN_SBC, FN_AND, FN_XOR, FN_OR, FN_CP,
            FN_INC, FN_DEC, FN_RLCA, FN_RRCA, FN_RLA, FN_RRA, FN_CPL, FN_SCF,
            FN_CCF, FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SWAP,
            FN_SRL, FN_BIT, FN_RES, FN_SET:
                res_next.result = {8'd0, r8};
            default:  res_next.result = op_reg.operand_a;
        endcase
    end

    // ---------------------------------------------------------------
    // Result register: hold while the output side stalls
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || m_axis_tready)
        begin
            res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg.flags.carry, res_reg.flags.half,
                            res_reg.flags.subtract, res_reg.flags.zero,
                            res_reg.result};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a result only appears after the operand stage held a word
    a_res_from_op: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(op_valid_reg))
        else $error("result valid without a pending operation");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> s_axis_tready)
        else $error("input stalled while result register is empty");

    // a stalled operand stage keeps its word
    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && !res_load |=> op_valid_reg && $stable(op_reg))
        else $error("operand register lost a word during a stall");

    // a stalled result register keeps its word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !m_axis_tready |=> res_valid_reg && $stable(res_reg))
        else $error("result register changed during a stall");

endmodule

@@ bench/tb_cpu8_alu_with_flags.sv @@
`timescale 1ns / 100ps

module tb_cpu8_alu_with_flags;
    import c8alu_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int MAX_GAP      = 17;
    localparam int RANDOM_OPS   = 750;
    localparam int STRETCH      = 48;      // items per idling stretch
    localparam int HOLD_AT      = 200;     // result count that starts the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 450;     // random item at which the sender drains the block
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // One operation as it travels in s_axis_tdata
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [WORD16_W-1:0]  operand_a;
        logic [WORD16_W-1:0]  operand_b;
        logic [BIT_IDX_W-1:0] bit_index;
        flags_t               flags;
    } alu_word_t;

    // Predicted results of accepted operations, oldest first
    class alu_result_board;
        alu_res_t expected_q[$];
        int       mismatches;

        // Compute result and new flags of one operation
        function alu_res_t alu_outcome(alu_word_t op);
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  r;
            logic [8:0]  wide;
            logic [4:0]  nib;
            logic [16:0] sum16;
            logic [12:0] low12;
            logic [15:0] r16;
            logic        cin;
            logic        use16;
            flags_t      f;
            alu_res_t    res;
            a     = op.operand_a[7:0];
            b     = op.operand_b[7:0];
            f     = op.flags;
            r     = a;
            r16   = op.operand_a;
            use16 = 1'b0;
            case (op.func)
                FN_ADD, FN_ADC:
                begin
                    cin        = (op.func == FN_ADC) ? f.carry : 1'b0;
                    wide       = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                    nib        = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                    r          = wide[7:0];
                    f.zero     = (r == 8'h00);
                    f.subtract = 1'b0;
                    f.half     = nib[4];
                    f.carry    = wide[8];
                end
                FN_SUB, FN_SBC, FN_CP:
                begin
                    // borrow shows up as the sign bit of the widened difference
                    cin        = (op.func == FN_SBC) ? f.carry : 1'b0;
                    wide       = {1'b0, a} - {1'b0, b} - {8'h00, cin};
                    nib        = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
                    r          = (op.func == FN_CP) ? a : wide[7:0];
                    f.zero     = (wide[7:0] == 8'h00);
                    f.subtract = 1'b1;
                    f.half     = nib[4];
                    f.carry    = wide[8];
                end
                FN_AND, FN_XOR, FN_OR:
                begin
                    r          = (op.func == FN_AND) ? (a & b) :
                                 (op.func == FN_XOR) ? (a ^ b) : (a | b);
                    f.zero     = (r == 8'h00);
                    f.subtract = 1'b0;
                    f.half     = (op.func == FN_AND);
                    f.carry    = 1'b0;
                end
                FN_INC:
                begin
                    r          = a + 8'd1;
                    f.zero     = (r == 8'h00);
                    f.subtract = 1'b0;
                    f.half     = (a[3:0] == 4'hF);
                end
                FN_DEC:
                begin
                    r          = a - 8'd1;
                    f.zero     = (r == 8'h00);
                    f.subtract = 1'b1;
                    f.half     = (a[3:0] == 4'h0);
                end
                FN_RLCA, FN_RLC, FN_RRCA, FN_RRC, FN_RLA, FN_RL, FN_RRA, FN_RR,
                FN_SLA, FN_SRA, FN_SRL:
                begin
                    case (op.func)
                        FN_RLCA, FN_RLC: r = {a[6:0], a[7]};
                        FN_RRCA, FN_RRC: r = {a[0], a[7:1]};
                        FN_RLA, FN_RL:   r = {a[6:0], f.carry};
                        FN_RRA, FN_RR:   r = {f.carry, a[7:1]};
                        FN_SLA:          r = {a[6:0], 1'b0};
                        FN_SRA:          r = {a[7], a[7:1]};
                        default:         r = {1'b0, a[7:1]};
                    endcase
                    // left moves push out bit 7, right moves bit 0
                    case (op.func)
                        FN_RLCA, FN_RLC, FN_RLA, FN_RL, FN_SLA: f.carry = a[7];
                        default:                                f.carry = a[0];
                    endcase
                    // accumulator rotates always clear zero
                    case (op.func)
                        FN_RLCA, FN_RRCA, FN_RLA, FN_RRA: f.zero = 1'b0;
                        default:                          f.zero = (r == 8'h00);
                    endcase
                    f.subtract = 1'b0;
                    f.half     = 1'b0;
                end
                FN_CPL:
                begin
                    r          = ~a;
                    f.subtract = 1'b1;
                    f.half     = 1'b1;
                end
                FN_SCF, FN_CCF:
                begin
                    f.subtract = 1'b0;
                    f.half     = 1'b0;
                    f.carry    = (op.func == FN_SCF) ? 1'b1 : ~f.carry;
                end
                FN_SWAP:
                begin
                    r          = {a[3:0], a[7:4]};
                    f.zero     = (r == 8'h00);
                    f.subtract = 1'b0;
                    f.half     = 1'b0;
                    f.carry    = 1'b0;
                end
                FN_BIT:
                begin
                    f.zero     = ~a[op.bit_index];
                    f.subtract = 1'b0;
                    f.half     = 1'b1;
                end
                FN_RES: r = a & ~(8'h01 << op.bit_index);
                FN_SET: r = a | (8'h01 << op.bit_index);
                FN_ADD16:
                begin
                    use16      = 1'b1;
                    sum16      = {1'b0, op.operand_a} + {1'b0, op.operand_b};
                    low12      = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
                    r16        = sum16[15:0];
                    f.subtract = 1'b0;
                    f.half     = low12[12];
                    f.carry    = sum16[16];
                end
                FN_INC16:
                begin
                    use16 = 1'b1;
                    r16   = op.operand_a + 16'd1;
                end
                FN_DEC16:
                begin
                    use16 = 1'b1;
                    r16   = op.operand_a - 16'd1;
                end
                default: use16 = 1'b1;   // unused code: pass everything through
            endcase
            res.result = use16 ? r16 : {8'h00, r};
            res.flags  = f;
            return res;
        endfunction

        function void note_op(alu_word_t op);
            expected_q.push_back(alu_outcome(op));
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] word);
            alu_res_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word 0x%06h arrived with no operation outstanding", word);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("result", want.result, word[15:0]);
            check_field("zero_out", want.flags.zero, word[16]);
            check_field("subtract_out", want.flags.subtract, word[17]);
            check_field("half_out", want.flags.half, word[18]);
            check_field("carry_out", want.flags.carry, word[19]);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // s_axis_tdata, low bit up: func, operand_a, operand_b, bit_index,
    // zero_in, subtract_in, half_in, carry_in, zero padding
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // m_axis_tdata, low bit up: result, zero_out, subtract_out, half_out,
    // carry_out, zero padding
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    alu_result_board board;
    int              ops_sent = 0;
    int              cycle_count = 0;

    cpu8_alu_with_flags dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Draw the idle gap ahead of one word; every third stretch runs with no idling
    function automatic int draw_gap(int n);
        if ((n / STRETCH) % 3 == 2)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Draw a 16-bit operand, leaning toward carry and borrow boundaries
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 7))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w[3:0] = 4'hF;
            3: w[3:0] = 4'h0;
            4: w[11:0] = 12'hFFF;
            default: ;
        endcase
        return w;
    endfunction

    function automatic alu_word_t make_op(logic [FUNC_W-1:0] func, logic [15:0] a,
                                          logic [15:0] b, logic [BIT_IDX_W-1:0] bi,
                                          flags_t f);
        alu_word_t op;
        op.func      = func;
        op.operand_a = a;
        op.operand_b = b;
        op.bit_index = bi;
        op.flags     = f;
        return op;
    endfunction

    // Offer one word and hold it until the block takes it. Call at a rising edge;
    // returns at the edge of acceptance with tvalid still high.
    task automatic send_op(alu_word_t op);
        int gap;
        gap = draw_gap(ops_sent);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, op.flags.carry, op.flags.half, op.flags.subtract,
                          op.flags.zero, op.bit_index, op.operand_b, op.operand_a,
                          op.func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_op(op);
        ops_sent++;
    endtask

    // Result side: idle at random per word, and once hold off long enough
    // for both stages to fill and back-pressure the input
    initial
    begin
        int gap;
        int words_taken;
        words_taken = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = draw_gap(words_taken + STRETCH / 2);
            if (words_taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            board.check_word(m_axis_tdata);
            words_taken++;
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [15:0] dir_a [4] = '{16'hFFFF, 16'h0000, 16'h0F0F, 16'h8001};
        logic [15:0] dir_b [4] = '{16'h0001, 16'h0000, 16'hF0F1, 16'h7FFF};
        alu_word_t   op;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk every function code, the unused one too, over operand extremes;
        // flip all incoming flags across the two halves
        for (int k = 0; k < 2**FUNC_W; k++)
            send_op(make_op(FUNC_W'(k), dir_a[k % 4], dir_b[k % 4], BIT_IDX_W'(k),
                            (k < 2**FUNC_W / 2) ? flags_t'(k) : flags_t'(~k)));

        // Half carry, full carry through the carry in, half borrow, borrow from
        // the carry in alone, compare of equal values, 16-bit boundaries
        send_op(make_op(FN_ADD,   16'h000F, 16'h0001, 3'd0, 4'b0000));
        send_op(make_op(FN_ADC,   16'h00FF, 16'h0000, 3'd0, 4'b0001));
        send_op(make_op(FN_SUB,   16'h0010, 16'h0001, 3'd0, 4'b1111));
        send_op(make_op(FN_SBC,   16'h0000, 16'h0000, 3'd0, 4'b0001));
        send_op(make_op(FN_CP,    16'hAB42, 16'h1242, 3'd0, 4'b0000));
        send_op(make_op(FN_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b1000));
        send_op(make_op(FN_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b0000));
        send_op(make_op(FN_BIT,   16'h0080, 16'h0000, 3'd7, 4'b0001));
        send_op(make_op(FN_DEC,   16'h0001, 16'h0000, 3'd0, 4'b0000));

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            // Drain the block once with the input idle
            if (n == PAUSE_AT)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (board.expected_q.size() != 0);
            end
            op.func      = FUNC_W'($urandom_range(0, 2**FUNC_W - 1));
            op.operand_a = pick_word();
            op.operand_b = pick_word();
            op.bit_index = BIT_IDX_W'($urandom);
            op.flags     = flags_t'($urandom);
            send_op(op);
        end

        // Drop valid, wait out the outstanding results, then keep watching
        // the output to catch any stray word
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
